// ===== rtl/fsa_pkg.sv =====
// shared types and constants for the flow to sequential address block
package fsa_pkg;

	localparam logic [7:0] PROTO_NUM_TCP = 8'd6;
	localparam logic [7:0] PROTO_NUM_UDP = 8'd17;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIDIRECTIONAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_PORTS = 1'b1;

	localparam logic [31:0] ADDR_FIRST = 32'd1;
	localparam logic [31:0] ADDR_LAST = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		STAT_HIT  = 2'd0,
		STAT_NEW  = 2'd1,
		STAT_FULL = 2'd2,
		STAT_DROP = 2'd3
	} flow_status_t;

	typedef struct packed {
		logic        cls;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] sport;
		logic [15:0] dport;
	} flow_key_t;

	typedef struct packed {
		logic        active;
		logic        bidir;
		flow_key_t   key;
		logic [31:0] addr;
		logic        fwd_hit;
		logic [31:0] fwd_val;
		logic        rev_hit;
		logic [31:0] rev_val;
		logic        ins;
	} query_t;

endpackage

// ===== rtl/fsa_if.sv =====
// item channels for packet headers and address results
interface fsa_pkt_if;
	logic        valid;
	logic        ready;
	logic        has_ip_header;
	logic [7:0]  protocol;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic [15:0] src_port;
	logic [15:0] dst_port;

	modport source (output valid, has_ip_header, protocol, src_addr, dst_addr,
		src_port, dst_port, input ready);
	modport sink (input valid, has_ip_header, protocol, src_addr, dst_addr,
		src_port, dst_port, output ready);
endinterface

interface fsa_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] new_dst_addr;

	modport source (output valid, status, new_dst_addr, input ready);
	modport sink (input valid, status, new_dst_addr, output ready);
endinterface

// ===== rtl/fsa_cell.sv =====
// one flow table entry: compares the passing query and takes the key when first free
module fsa_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  fsa_pkg::query_t q_in,
	output fsa_pkg::query_t q_out
);
	import fsa_pkg::*;

	logic        valid_q;
	flow_key_t   key_q;
	logic [31:0] val_q;
	query_t      q_out_q;
	flow_key_t   rev_key;
	logic        hit_f;
	logic        hit_r;
	logic        take;
	query_t      q_nxt;

	always_comb begin
		rev_key.cls   = q_in.key.cls;
		rev_key.src   = q_in.key.dst;
		rev_key.dst   = q_in.key.src;
		rev_key.sport = q_in.key.dport;
		rev_key.dport = q_in.key.sport;
		hit_f = valid_q && (key_q == q_in.key);
		hit_r = valid_q && q_in.bidir && (key_q == rev_key);
		take  = q_in.active && !valid_q && !q_in.fwd_hit && !q_in.rev_hit && !q_in.ins;
		q_nxt = q_in;
		if (hit_f && !q_in.fwd_hit) begin
			q_nxt.fwd_hit = 1'b1;
			q_nxt.fwd_val = val_q;
		end
		if (hit_r && !q_in.rev_hit) begin
			q_nxt.rev_hit = 1'b1;
			q_nxt.rev_val = val_q;
		end
		if (take) begin
			q_nxt.ins = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			q_out_q <= '0;
		end else begin
			q_out_q <= q_nxt;
			if (take) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_q <= q_in.key;
			val_q <= q_in.addr;
		end
	end

	assign q_out = q_out_q;

endmodule

// ===== rtl/flow_to_sequential_address.sv =====
// top level: flow table as a chain of entry cells with sequential address assignment
//
// Each packet header is looked up against a table of FLOW_ENTRIES flows held in a
// chain of cells, one entry per cell. The query walks one cell per cycle, so a
// header that is looked up passes the launch register, each cell and the result
// register; a dropped header (no IP header, or not TCP/UDP with ports in use) gives
// its result in the cycle after acceptance. One header is in the table at a time.
// The first free cell the query meets takes the new flow, so entries fill in order
// and are never freed; addresses count up from 1 and wrap past the top back to 1.
// Configuration is written through cfg_we/cfg_idx/cfg_data while no header is in
// flight.
module flow_to_sequential_address #(
	parameter int FLOW_ENTRIES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	fsa_pkt_if.sink                             pkt,
	fsa_res_if.source                           res,
	input  logic                                cfg_we,
	input  logic [fsa_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic                                cfg_data
);
	import fsa_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_SEARCH = 2'b10
	} state_t;

	state_t       state_q;
	logic         bidir_q;
	logic         use_ports_q;
	logic [31:0]  next_q;
	query_t       launch_q;
	query_t       launch_nxt;
	query_t       chain [FLOW_ENTRIES+1];
	query_t       tail;
	logic         res_valid_q;
	flow_status_t res_status_q;
	logic [31:0]  res_addr_q;
	logic         acc;
	logic         drop;
	logic         done;
	flow_status_t done_status;
	logic [31:0]  done_addr;

	assign pkt.ready = (state_q == ST_IDLE) && (!res_valid_q || res.ready);
	assign acc = pkt.valid && pkt.ready;
	assign drop = !pkt.has_ip_header || (use_ports_q && (pkt.protocol != PROTO_NUM_TCP)
		&& (pkt.protocol != PROTO_NUM_UDP));

	always_comb begin
		launch_nxt           = '0;
		launch_nxt.active    = 1'b1;
		launch_nxt.bidir     = bidir_q;
		launch_nxt.key.cls   = (pkt.protocol == PROTO_NUM_TCP);
		launch_nxt.key.src   = pkt.src_addr;
		launch_nxt.key.dst   = pkt.dst_addr;
		launch_nxt.key.sport = use_ports_q ? pkt.src_port : 16'd0;
		launch_nxt.key.dport = use_ports_q ? pkt.dst_port : 16'd0;
		launch_nxt.addr      = next_q;
	end

	assign chain[0] = launch_q;

	for (genvar i = 0; i < FLOW_ENTRIES; i++) begin : g_cell
		fsa_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.q_in   (chain[i]),
			.q_out  (chain[i+1])
		);
	end

	assign tail = chain[FLOW_ENTRIES];
	assign done = tail.active;

	always_comb begin
		if (tail.fwd_hit) begin
			done_status = STAT_HIT;
			done_addr   = tail.fwd_val;
		end else if (tail.rev_hit) begin
			done_status = STAT_HIT;
			done_addr   = tail.rev_val;
		end else if (tail.ins) begin
			done_status = STAT_NEW;
			done_addr   = tail.addr;
		end else begin
			done_status = STAT_FULL;
			done_addr   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			bidir_q      <= 1'b0;
			use_ports_q  <= 1'b1;
			next_q       <= ADDR_FIRST;
			launch_q     <= '0;
			res_valid_q  <= 1'b0;
			res_status_q <= STAT_HIT;
			res_addr_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_BIDIRECTIONAL: bidir_q <= cfg_data;
					CFG_USE_PORTS:     use_ports_q <= cfg_data;
					default:           ;
				endcase
			end
			if ((state_q == ST_IDLE) && acc && !drop) begin
				launch_q <= launch_nxt;
			end else begin
				launch_q.active <= 1'b0;
			end
			if (((state_q == ST_IDLE) && acc && drop) || ((state_q == ST_SEARCH) && done)) begin
				res_valid_q <= 1'b1;
			end else if (res.valid && res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (drop) begin
							res_status_q <= STAT_DROP;
							res_addr_q   <= '0;
						end else begin
							state_q  <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (done) begin
						res_status_q <= done_status;
						res_addr_q   <= done_addr;
						state_q      <= ST_IDLE;
						if (tail.ins) begin
							next_q <= (next_q == ADDR_LAST) ? ADDR_FIRST : next_q + 32'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid        = res_valid_q;
	assign res.status       = res_status_q;
	assign res.new_dst_addr = res_addr_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_tail_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_SEARCH))
		else $error("query left the chain outside a search");

	a_addr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_q != '0)
		else $error("address counter reached zero");

	a_new_takes_counter: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !tail.fwd_hit && !tail.rev_hit && tail.ins) |=>
		(res_status_q == STAT_NEW) && (res_addr_q == $past(next_q)))
		else $error("new flow not given the counter value");

endmodule

// ===== tb/sv/tb_flow_to_sequential_address.sv =====
// self-checking testbench for the flow to sequential address block with random handshakes
module tb_flow_to_sequential_address;
	timeunit 1ns;
	timeprecision 1ps;

	import fsa_pkg::*;

	localparam int FLOW_ENTRIES = 64;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 165;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE = FLOW_ENTRIES + 4;
	localparam longint CYCLE_LIMIT = 3_000_000;

	typedef struct packed {
		logic        has_ip;
		logic [7:0]  proto;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] sport;
		logic [15:0] dport;
	} pkt_hdr_t;

	typedef struct {
		flow_status_t status;
		logic [31:0]  addr;
	} flow_result_t;

	class flow_addr_scoreboard;
		flow_key_t    keys[FLOW_ENTRIES];
		logic [31:0]  addrs[FLOW_ENTRIES];
		bit           used[FLOW_ENTRIES];
		logic [31:0]  next_addr;
		bit           bidir;
		bit           ports_on;
		flow_result_t outstanding[$];
		int           tally[4];
		int           mismatches;
		int           checked;

		function new();
			foreach (used[i]) used[i] = 1'b0;
			foreach (tally[i]) tally[i] = 0;
			next_addr = ADDR_FIRST;
			bidir = 1'b0;
			ports_on = 1'b1;
			mismatches = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic val);
			if (idx == CFG_BIDIRECTIONAL) begin
				bidir = val;
			end else if (idx == CFG_USE_PORTS) begin
				ports_on = val;
			end
		endfunction

		function int find_flow(flow_key_t k);
			foreach (used[i]) begin
				if (used[i] && keys[i] == k) return i;
			end
			return -1;
		endfunction

		// works out the result of one accepted header and queues it
		function flow_status_t note_header(pkt_hdr_t h);
			flow_key_t fwd;
			flow_key_t rev;
			flow_result_t r;
			int idx;
			int slot;
			r.addr = '0;
			if (!h.has_ip || (ports_on && h.proto != PROTO_NUM_TCP &&
					h.proto != PROTO_NUM_UDP)) begin
				r.status = STAT_DROP;
			end else begin
				fwd.cls = (h.proto == PROTO_NUM_TCP);
				fwd.src = h.src;
				fwd.dst = h.dst;
				fwd.sport = ports_on ? h.sport : 16'h0;
				fwd.dport = ports_on ? h.dport : 16'h0;
				idx = find_flow(fwd);
				if (idx < 0 && bidir) begin
					rev.cls = fwd.cls;
					rev.src = fwd.dst;
					rev.dst = fwd.src;
					rev.sport = fwd.dport;
					rev.dport = fwd.sport;
					idx = find_flow(rev);
				end
				if (idx >= 0) begin
					r.status = STAT_HIT;
					r.addr = addrs[idx];
				end else begin
					slot = -1;
					foreach (used[i]) begin
						if (!used[i] && slot < 0) slot = i;
					end
					if (slot < 0) begin
						r.status = STAT_FULL;
					end else begin
						keys[slot] = fwd;
						addrs[slot] = next_addr;
						used[slot] = 1'b1;
						r.status = STAT_NEW;
						r.addr = next_addr;
						next_addr = (next_addr == ADDR_LAST) ? ADDR_FIRST :
							next_addr + 32'd1;
					end
				end
			end
			outstanding.push_back(r);
			tally[r.status]++;
			return r.status;
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
		endfunction

		function void check_result(logic [1:0] st, logic [31:0] addr);
			flow_result_t e;
			checked++;
			if (outstanding.size() == 0) begin
				report($sformatf("result status %0d addr %h with nothing outstanding",
					st, addr));
				return;
			end
			e = outstanding.pop_front();
			if (st !== e.status)
				report($sformatf("status expected %0d actual %0d", e.status, st));
			if (addr !== e.addr)
				report($sformatf("new_dst_addr expected %h actual %h", e.addr, addr));
		endfunction

		function int pending();
			return outstanding.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic                 cfg_data;

	fsa_pkt_if pkt_ch();
	fsa_res_if res_ch();

	flow_to_sequential_address #(
		.FLOW_ENTRIES(FLOW_ENTRIES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt(pkt_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	flow_addr_scoreboard sb = new();
	pkt_hdr_t known_flows[$];
	bit hold_off_req = 1'b0;
	bit steady = 1'b0;
	int holds_done = 0;
	int settings = 0;
	int hdrs_sent = 0;
	longint cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				sb.pending());
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
			sb.check_result(res_ch.status, res_ch.new_dst_addr);
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 4);
		if (r < 97) return $urandom_range(5, 40);
		return $urandom_range(41, 150);
	endfunction

	function automatic pkt_hdr_t swap_dir(pkt_hdr_t h);
		pkt_hdr_t s;
		s = h;
		s.src = h.dst;
		s.dst = h.src;
		s.sport = h.dport;
		s.dport = h.sport;
		return s;
	endfunction

	function automatic pkt_hdr_t random_hdr();
		pkt_hdr_t h;
		h.has_ip = 1'b1;
		h.proto = $urandom_range(0, 1) ? PROTO_NUM_TCP : PROTO_NUM_UDP;
		h.src = $urandom;
		h.dst = $urandom;
		h.sport = 16'($urandom_range(0, 65535));
		h.dport = 16'($urandom_range(0, 65535));
		return h;
	endfunction

	// receiver side
	initial begin
		int n;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				res_ch.ready = 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				holds_done++;
				hold_off_req = 1'b0;
			end else if (steady || $urandom_range(0, 99) < 70) begin
				res_ch.ready = 1'b1;
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
					$urandom_range(1, 40);
				repeat (n - 1) @(negedge clk);
			end else begin
				res_ch.ready = 1'b0;
				n = gap_len() + 1;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	task automatic send_hdr(pkt_hdr_t h);
		@(negedge clk);
		pkt_ch.has_ip_header = h.has_ip;
		pkt_ch.protocol = h.proto;
		pkt_ch.src_addr = h.src;
		pkt_ch.dst_addr = h.dst;
		pkt_ch.src_port = h.sport;
		pkt_ch.dst_port = h.dport;
		pkt_ch.valid = 1'b1;
		do @(posedge clk); while (pkt_ch.ready !== 1'b1);
		if (sb.note_header(h) == STAT_NEW) known_flows.push_back(h);
		hdrs_sent++;
	endtask

	task automatic idle_sender(int n);
		if (n > 0) begin
			@(negedge clk);
			pkt_ch.valid = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		pkt_ch.valid = 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic set_mode(logic bd, logic up);
		drain();
		write_reg(CFG_BIDIRECTIONAL, bd);
		write_reg(CFG_USE_PORTS, up);
		settings++;
	endtask

	initial begin
		pkt_hdr_t h;
		int r;
		int p;
		int i;
		logic bd;
		logic up;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_BIDIRECTIONAL;
		cfg_data = 1'b0;
		pkt_ch.valid = 1'b0;
		pkt_ch.has_ip_header = 1'b0;
		pkt_ch.protocol = '0;
		pkt_ch.src_addr = '0;
		pkt_ch.dst_addr = '0;
		pkt_ch.src_port = '0;
		pkt_ch.dst_port = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: one-way, ports in key
		send_hdr('{1'b0, PROTO_NUM_TCP, 32'h0A00_0001, 32'h0A00_0002, 16'd1, 16'd2});
		send_hdr('{1'b1, 8'd0, 32'h0A00_0001, 32'h0A00_0002, 16'd1, 16'd2});
		send_hdr('{1'b1, 8'hFF, 32'h0A00_0001, 32'h0A00_0002, 16'd1, 16'd2});
		send_hdr('{1'b1, PROTO_NUM_UDP - 8'd1, 32'h0A00_0001, 32'h0A00_0002,
			16'd1, 16'd2});
		send_hdr('{1'b1, PROTO_NUM_TCP, 32'h0, 32'h0, 16'h0, 16'h0});
		send_hdr('{1'b1, PROTO_NUM_TCP, 32'h0, 32'h0, 16'h0, 16'h0});
		send_hdr('{1'b1, PROTO_NUM_UDP, 32'h0, 32'h0, 16'h0, 16'h0});
		send_hdr('{1'b1, PROTO_NUM_TCP, '1, '1, '1, '1});
		h = '{1'b1, PROTO_NUM_TCP, 32'h0A00_0001, 32'hC0A8_0001, 16'h1234, 16'h0050};
		send_hdr(h);
		send_hdr(swap_dir(h));

		// reversed key matching
		set_mode(1'b1, 1'b1);
		send_hdr('{1'b1, PROTO_NUM_UDP, 32'h0B00_0001, 32'h0C00_0001, 16'd53, 16'd4000});
		send_hdr('{1'b1, PROTO_NUM_UDP, 32'h0C00_0001, 32'h0B00_0001, 16'd4000, 16'd53});
		send_hdr(swap_dir(h));
		send_hdr('{1'b1, PROTO_NUM_TCP, 32'h0C00_0001, 32'h0B00_0001, 16'd4000, 16'd53});

		// ports left out of the key, any protocol taken
		set_mode(1'b0, 1'b0);
		send_hdr('{1'b1, 8'd1, 32'h0102_0304, 32'h0506_0708, 16'hFFFF, 16'h0001});
		send_hdr('{1'b1, 8'd47, 32'h0102_0304, 32'h0506_0708, 16'h0007, 16'h0009});
		send_hdr('{1'b1, PROTO_NUM_TCP, 32'h0, 32'h0, 16'd8080, 16'd443});
		send_hdr('{1'b0, PROTO_NUM_UDP, 32'h0102_0304, 32'h0506_0708, 16'h0, 16'h0});
		send_hdr('{1'b1, 8'hFF, '1, 32'h0, 16'h0, '1});
		set_mode(1'b1, 1'b0);
		send_hdr('{1'b1, 8'd1, 32'h0506_0708, 32'h0102_0304, 16'h0003, 16'h0004});

		for (p = 0; p < PHASES; p++) begin
			if (p < 4) begin
				bd = p[0];
				up = !p[1];
			end else begin
				bd = 1'($urandom_range(0, 1));
				up = 1'($urandom_range(0, 1));
			end
			set_mode(bd, up);
			steady = (p == 2);
			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (p == 1 && i == 20) hold_off_req = 1'b1;
				// sender waits here until every result is back
				if (p == 5 && i == ITEMS_PER_PHASE / 2) drain();
				r = $urandom_range(0, 99);
				if (r < 45 && known_flows.size() > 0) begin
					h = known_flows[$urandom_range(0, known_flows.size() - 1)];
					if ($urandom_range(0, 3) == 0) h = swap_dir(h);
					if (!up && $urandom_range(0, 1)) begin
						h.sport = 16'($urandom_range(0, 65535));
						h.dport = 16'($urandom_range(0, 65535));
					end
				end else if (r < 65 || known_flows.size() == 0) begin
					h = random_hdr();
				end else if (r < 80) begin
					// near miss on a known flow
					h = known_flows[$urandom_range(0, known_flows.size() - 1)];
					case ($urandom_range(0, 4))
						0: h.src ^= 32'h1 << $urandom_range(0, 31);
						1: h.dst ^= 32'h1 << $urandom_range(0, 31);
						2: h.sport ^= 16'h1 << $urandom_range(0, 15);
						3: h.dport ^= 16'h1 << $urandom_range(0, 15);
						default: h.proto = (h.proto == PROTO_NUM_TCP) ?
							PROTO_NUM_UDP : PROTO_NUM_TCP;
					endcase
				end else begin
					h = random_hdr();
					h.has_ip = ($urandom_range(0, 4) != 0);
					h.proto = 8'($urandom_range(0, 255));
				end
				if (!steady) idle_sender(gap_len());
				send_hdr(h);
			end
		end
		steady = 1'b0;
		drain();

		$display("%0d headers over %0d register settings: %0d hits, %0d new flows,",
			hdrs_sent, settings + 1, sb.tally[STAT_HIT], sb.tally[STAT_NEW]);
		$display("%0d table full, %0d dropped, %0d results checked",
			sb.tally[STAT_FULL], sb.tally[STAT_DROP], sb.checked);
		$display("%0d long receiver hold-offs of %0d cycles, %0d cycles",
			holds_done, LONG_HOLD, cycle_count);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/fsa_pkg.sv
rtl/fsa_if.sv
rtl/fsa_cell.sv
rtl/flow_to_sequential_address.sv
tb/sv/tb_flow_to_sequential_address.sv
